// ----- rtl/papt_pkg.sv -----
// shared constants and types of the pending access point table
package papt_pkg;

  // table geometry and field widths
  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrBits   = 48;
  localparam int unsigned CountBits  = 32;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpExists = 2'd1,
    OpUpdate = 2'd2,
    OpKilled = 2'd3
  } op_e;

  // request travelling down the row of cells
  typedef struct packed {
    op_e                  op;
    logic [AddrBits-1:0]  mem_address;
    logic [AddrBits-1:0]  instr_address;
    logic                 is_write;
    logic [CountBits-1:0] count;
    logic                 done;
    logic                 hit;
  } token_t;

endpackage

// ----- rtl/papt_in_if.sv -----
// request channel of the pending access point table
interface papt_in_if
  import papt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [AddrBits-1:0]  mem_address;
  logic [AddrBits-1:0]  instr_address;
  logic                 is_write;
  logic [CountBits-1:0] initial_count;

  modport source (
    output valid, operation, mem_address, instr_address, is_write, initial_count,
    input  ready
  );
  modport sink (
    input  valid, operation, mem_address, instr_address, is_write, initial_count,
    output ready
  );
endinterface

// ----- rtl/papt_out_if.sv -----
// result channel of the pending access point table
interface papt_out_if
  import papt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [CountBits-1:0] access_count;
  logic                 table_full;

  modport source (
    output valid, hit, access_count, table_full,
    input  ready
  );
  modport sink (
    input  valid, hit, access_count, table_full,
    output ready
  );
endinterface

// ----- rtl/papt_cell.sv -----
// one table slot: holds an access point and serves the request passing through
module papt_cell
  import papt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   tok_valid_i,
  input  token_t tok_i,
  output logic   tok_valid_o,
  output token_t tok_o
);

  logic                 valid_q, valid_d;
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic [AddrBits-1:0]  pc_q, pc_d;
  logic                 wr_q, wr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 killed_q, killed_d;
  logic                 tok_valid_q;
  token_t               tok_q, tok_d;

  logic                 active;
  logic                 addr_eq;
  logic                 point_eq;
  logic [CountBits-1:0] count_inc;

  // compare the passing request against this slot
  assign active    = tok_valid_i && !tok_i.done;
  assign addr_eq   = valid_q && (addr_q == tok_i.mem_address);
  assign point_eq  = addr_eq && (pc_q == tok_i.instr_address) && (wr_q == tok_i.is_write);
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  // slot update and request hand-over
  always_comb begin
    valid_d  = valid_q;
    addr_d   = addr_q;
    pc_d     = pc_q;
    wr_d     = wr_q;
    count_d  = count_q;
    killed_d = killed_q;
    tok_d    = tok_i;
    if (active) begin
      case (tok_i.op)
        OpInsert: begin
          // first free slot takes the point
          if (!valid_q) begin
            valid_d   = 1'b1;
            addr_d    = tok_i.mem_address;
            pc_d      = tok_i.instr_address;
            wr_d      = tok_i.is_write;
            count_d   = tok_i.count;
            killed_d  = tok_i.is_write;
            tok_d.done = 1'b1;
            tok_d.hit  = 1'b1;
          end
        end
        OpExists: begin
          if (point_eq) begin
            tok_d.done = 1'b1;
            tok_d.hit  = 1'b1;
          end
        end
        OpUpdate: begin
          // a killed point of the address ends the scan with failure
          if (addr_eq && killed_q) begin
            tok_d.done = 1'b1;
          end else if (point_eq) begin
            count_d     = count_inc;
            tok_d.count = count_inc;
            tok_d.done  = 1'b1;
            tok_d.hit   = 1'b1;
          end
        end
        OpKilled: begin
          if (addr_eq && killed_q) begin
            tok_d.done = 1'b1;
            tok_d.hit  = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q     <= valid_d;
      tok_valid_q <= tok_valid_i;
    end
  end

  // slot contents and request register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      addr_q   <= addr_d;
      pc_q     <= pc_d;
      wr_q     <= wr_d;
      count_q  <= count_d;
      killed_q <= killed_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ----- rtl/pending_access_point_table_top.sv -----
// top level of the pending access point table: row of slot cells and result register
// A request word enters the first of TableDepth (64) slot cells and moves one cell per
// clock down the row while the row is not stalled. Each cell compares it with the point
// it holds, stores an insert in the first free slot, bumps a matching count or ends the
// search. From the last cell the request enters the result register, which then shows
// the result as valid. One word is in the row at a time. A new word is taken in the cycle
// after the previous one has left the row, even while the previous result still waits
// on the output. Slots fill in order and are never freed; an insert that finds no free
// slot returns table_full.
module pending_access_point_table_top
  import papt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  papt_in_if.sink     in_i,
  papt_out_if.source  out_o
);

  logic   tok_valid [TableDepth+1];
  token_t tok       [TableDepth+1];

  logic                 adv;
  logic                 busy_q, busy_d;
  logic                 accept;
  logic                 exit_w;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_hit_d;
  logic [CountBits-1:0] out_count_q, out_count_d;
  logic                 out_full_q, out_full_d;

  // row stalls only while a finished request cannot enter the result register
  assign adv    = !(tok_valid[TableDepth] && out_valid_q && !out_o.ready);
  assign accept = in_i.valid && in_i.ready;
  assign exit_w = tok_valid[TableDepth] && adv;

  assign in_i.ready = !busy_q;

  // request word entering the row
  assign tok_valid[0]         = accept;
  assign tok[0].op            = op_e'(in_i.operation);
  assign tok[0].mem_address   = in_i.mem_address;
  assign tok[0].instr_address = in_i.instr_address;
  assign tok[0].is_write      = in_i.is_write;
  assign tok[0].count         = in_i.initial_count;
  assign tok[0].done          = 1'b0;
  assign tok[0].hit           = 1'b0;

  // row of slot cells
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    papt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .tok_valid_i (tok_valid[g]),
      .tok_i       (tok[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_o       (tok[g+1])
    );
  end

  // occupancy of the row and result register
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_count_d = out_count_q;
    out_full_d  = out_full_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exit_w) begin
      busy_d = 1'b0;
    end
    if (exit_w) begin
      out_valid_d = 1'b1;
      out_hit_d   = tok[TableDepth].hit;
      out_count_d = (tok[TableDepth].op == OpUpdate && tok[TableDepth].hit) ?
                    tok[TableDepth].count : '0;
      out_full_d  = (tok[TableDepth].op == OpInsert) && !tok[TableDepth].done;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q   <= out_hit_d;
    out_count_q <= out_count_d;
    out_full_q  <= out_full_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = out_hit_q;
  assign out_o.access_count = out_count_q;
  assign out_o.table_full   = out_full_q;

endmodule
